// ----- rtl/scl_pkg.sv -----
// Shared types, constants and the command name table of the command line parser.
`default_nettype none

package scl_pkg;

  localparam int LINE_LIMIT_DEF = 128;

  localparam int CMD_COUNT = 5;
  localparam int NAME_MAX  = 6;

  typedef enum logic [2:0] {
    OP_HELP   = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_SWITCH = 3'd3,
    OP_STATUS = 3'd4
  } cmd_t;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_VT    = 8'd11;
  localparam logic [7:0] CHAR_FF    = 8'd12;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef logic [0:NAME_MAX-1][7:0] name_t;

  localparam name_t CMD_NAMES [CMD_COUNT] = '{
    {"help", 16'h0000},
    {"start", 8'h00},
    {"stop", 16'h0000},
    "switch",
    "status"
  };

  localparam logic [2:0] CMD_LEN [CMD_COUNT] = '{3'd4, 3'd5, 3'd4, 3'd6, 3'd6};

  // Number reader phases, in the order a token passes through them.
  typedef enum logic [1:0] {
    NUM_LEAD   = 2'd0,
    NUM_SIGN   = 2'd1,
    NUM_DIGITS = 2'd2,
    NUM_STOP   = 2'd3
  } num_phase_t;

  typedef struct packed {
    logic step;     // a word is processed this cycle
    logic restart;  // start from the cleared line state
    logic feed;     // the word belongs to this unit's token
  } name_ctl_t;

  typedef struct packed {
    logic step;
    logic restart;
    logic feed;
    logic stop;     // a fourth token began; stop reading this number
  } num_ctl_t;

  typedef struct packed {
    logic hit;
    cmd_t cmd;
  } name_res_t;

endpackage

`default_nettype wire

// ----- rtl/serial_command_line_parser_top.sv -----
// Top level of the serial command line parser.
`default_nettype none

// The parser takes one received word per cycle and reports one result word
// for each completed line whose first token is help, start, stop, switch or
// status, carrying up to two decimal parameters read in the manner of strtoul.
// A word is held in an input register, and when it is processed it updates
// the line state (token count, name candidates and two number readers, each
// with a single multiply-by-ten add) and, on CR or LF, loads the result
// register. The result word is offered once the CR or LF that ends its line
// has left the input register, and one word is accepted every cycle as long as
// the result side takes results when they are offered; while a result word
// waits, no received word is processed. A line that reaches LINE_LIMIT-1
// stored words is dropped before the next word is taken. Lines that are
// empty, blank or start with an unknown token give no result.
module serial_command_line_parser_top #(
  parameter int LINE_LIMIT = scl_pkg::LINE_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_char,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_command,
  output logic [31:0]      out_first_value,
  output logic [31:0]      out_second_value,
  output logic [1:0]       out_value_count
);

  localparam int CNT_W = $clog2(LINE_LIMIT);

  // Input register.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_char_r;
  logic       proc;

  // Line state.
  logic [CNT_W-1:0] stored_r, stored_nxt;
  logic [1:0]       tokens_r, tokens_nxt;
  logic             inside_r, inside_nxt;

  // Result register.
  logic        out_vld_r, out_vld_nxt;
  logic [2:0]  cmd_r;
  logic [31:0] val0_r;
  logic [31:0] val1_r;
  logic [1:0]  cnt_r;

  logic full;
  logic eol;
  logic is_space;
  logic result_hit;
  logic [1:0] nvals;

  scl_pkg::name_ctl_t name_ctl;
  scl_pkg::num_ctl_t  num0_ctl;
  scl_pkg::num_ctl_t  num1_ctl;
  scl_pkg::name_res_t name_res;
  logic [31:0]        num0_value;
  logic [31:0]        num1_value;

  // A held word is processed whenever the result register is free or being
  // emptied in this cycle, so the input side never waits on an idle output.
  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (proc) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_char_r <= in_rx_char;
    end
  end

  assign full     = (stored_r >= CNT_W'(LINE_LIMIT - 1));
  assign eol      = (in_char_r == scl_pkg::CHAR_CR) || (in_char_r == scl_pkg::CHAR_LF);
  assign is_space = (in_char_r == scl_pkg::CHAR_SPACE);

  // Line bookkeeping. A full line is cleared before the word is applied, so
  // every unit starts from the cleared state in that case.
  always_comb begin
    logic [CNT_W-1:0] stored_b;
    logic [1:0]       tokens_b;
    logic             inside_b;
    logic             starting;
    stored_b   = full ? '0 : stored_r;
    tokens_b   = full ? '0 : tokens_r;
    inside_b   = full ? 1'b0 : inside_r;
    starting   = !eol && !is_space && !inside_b;
    stored_nxt = stored_b;
    tokens_nxt = tokens_b;
    inside_nxt = inside_b;
    if (eol) begin
      stored_nxt = '0;
      tokens_nxt = '0;
      inside_nxt = 1'b0;
    end else begin
      stored_nxt = stored_b + CNT_W'(1);
      inside_nxt = !is_space;
      if (starting && (tokens_b != 2'd3)) begin
        tokens_nxt = tokens_b + 2'd1;
      end
    end

    name_ctl.step    = proc;
    name_ctl.restart = full || eol;
    name_ctl.feed    = !eol && !is_space && (tokens_nxt == 2'd1);

    num0_ctl.step    = proc;
    num0_ctl.restart = full || eol;
    num0_ctl.feed    = !eol && !is_space && (tokens_nxt == 2'd2);
    num0_ctl.stop    = 1'b0;

    // Any token past the third stops the second number where it stands.
    num1_ctl.step    = proc;
    num1_ctl.restart = full || eol;
    num1_ctl.feed    = !eol && !is_space && (tokens_nxt == 2'd3);
    num1_ctl.stop    = starting && (tokens_b == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      tokens_r <= '0;
      inside_r <= 1'b0;
    end else if (proc) begin
      stored_r <= stored_nxt;
      tokens_r <= tokens_nxt;
      inside_r <= inside_nxt;
    end
  end

  scl_name_match u_name (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (name_ctl),
    .rx_char (in_char_r),
    .res     (name_res)
  );

  scl_number u_num0 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (num0_ctl),
    .rx_char (in_char_r),
    .value   (num0_value)
  );

  scl_number u_num1 (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (num1_ctl),
    .rx_char (in_char_r),
    .value   (num1_value)
  );

  // A line end yields a result only for a non-empty line with a known name.
  assign result_hit = proc && eol && !full && (stored_r != '0) && (tokens_r != 2'd0) &&
                      name_res.hit;
  assign nvals      = (tokens_r == 2'd3) ? 2'd2 : (tokens_r - 2'd1);

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (result_hit) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result_hit) begin
      cmd_r  <= name_res.cmd;
      val0_r <= (nvals != 2'd0) ? num0_value : 32'd0;
      val1_r <= (nvals == 2'd2) ? num1_value : 32'd0;
      cnt_r  <= nvals;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_command      = cmd_r;
  assign out_first_value  = val0_r;
  assign out_second_value = val1_r;
  assign out_value_count  = cnt_r;

endmodule

`default_nettype wire

// ----- rtl/scl_name_match.sv -----
// Matches the first token of a line against the command names.
`default_nettype none

module scl_name_match (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scl_pkg::name_ctl_t ctl,
  input  wire logic [7:0]        rx_char,
  output scl_pkg::name_res_t     res
);

  logic [scl_pkg::CMD_COUNT-1:0] cand_r, cand_nxt;
  logic [2:0]                    pos_r, pos_nxt;

  always_comb begin
    logic [scl_pkg::CMD_COUNT-1:0] cand_b;
    logic [2:0]                    pos_b;
    cand_b   = ctl.restart ? '1 : cand_r;
    pos_b    = ctl.restart ? '0 : pos_r;
    cand_nxt = cand_b;
    pos_nxt  = pos_b;
    if (ctl.feed) begin
      if (pos_b == 3'd7) begin
        cand_nxt = '0;
      end else begin
        for (int i = 0; i < scl_pkg::CMD_COUNT; i++) begin
          if (!((pos_b < scl_pkg::CMD_LEN[i]) &&
                (scl_pkg::CMD_NAMES[i][pos_b] == rx_char))) begin
            cand_nxt[i] = 1'b0;
          end
        end
        pos_nxt = pos_b + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '1;
      pos_r  <= '0;
    end else if (ctl.step) begin
      cand_r <= cand_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Lowest-numbered surviving name whose length equals the token length.
  always_comb begin
    res.hit = 1'b0;
    res.cmd = scl_pkg::OP_HELP;
    for (int i = scl_pkg::CMD_COUNT - 1; i >= 0; i--) begin
      if (cand_r[i] && (scl_pkg::CMD_LEN[i] == pos_r)) begin
        res.hit = 1'b1;
        res.cmd = scl_pkg::cmd_t'(i[2:0]);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scl_number.sv -----
// Reads one decimal parameter token with saturation and optional sign.
`default_nettype none

module scl_number (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scl_pkg::num_ctl_t ctl,
  input  wire logic [7:0]       rx_char,
  output logic [31:0]           value
);

  scl_pkg::num_phase_t phase_r, phase_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic                ovf_r, ovf_nxt;

  logic       is_digit;
  logic       is_ws;
  logic       is_sign;
  logic [3:0] digit;
  logic [35:0] prod;

  assign is_digit = (rx_char >= scl_pkg::CHAR_ZERO) && (rx_char <= scl_pkg::CHAR_NINE);
  assign is_ws    = (rx_char == scl_pkg::CHAR_TAB) || (rx_char == scl_pkg::CHAR_VT) ||
                    (rx_char == scl_pkg::CHAR_FF);
  assign is_sign  = (rx_char == scl_pkg::CHAR_PLUS) || (rx_char == scl_pkg::CHAR_MINUS);
  assign digit    = 4'(rx_char - scl_pkg::CHAR_ZERO);

  // Next phase.
  always_comb begin
    scl_pkg::num_phase_t ph;
    ph = ctl.restart ? scl_pkg::NUM_LEAD : phase_r;
    if (ctl.stop) begin
      ph = scl_pkg::NUM_STOP;
    end
    phase_nxt = ph;
    if (ctl.feed) begin
      unique case (ph)
        scl_pkg::NUM_LEAD: begin
          if (is_ws) begin
            phase_nxt = scl_pkg::NUM_LEAD;
          end else if (is_sign) begin
            phase_nxt = scl_pkg::NUM_SIGN;
          end else if (is_digit) begin
            phase_nxt = scl_pkg::NUM_DIGITS;
          end else begin
            phase_nxt = scl_pkg::NUM_STOP;
          end
        end
        scl_pkg::NUM_SIGN, scl_pkg::NUM_DIGITS: begin
          phase_nxt = is_digit ? scl_pkg::NUM_DIGITS : scl_pkg::NUM_STOP;
        end
        scl_pkg::NUM_STOP: phase_nxt = scl_pkg::NUM_STOP;
        default:           phase_nxt = scl_pkg::NUM_STOP;
      endcase
    end
  end

  // Accumulator and flags. Times ten is formed as times eight plus times two.
  always_comb begin
    logic [31:0] acc_b;
    logic        neg_b;
    logic        ovf_b;
    acc_b   = ctl.restart ? '0 : acc_r;
    neg_b   = ctl.restart ? 1'b0 : neg_r;
    ovf_b   = ctl.restart ? 1'b0 : ovf_r;
    prod    = {1'b0, acc_b, 3'b000} + {3'b000, acc_b, 1'b0} + 36'(digit);
    acc_nxt = acc_b;
    neg_nxt = neg_b;
    ovf_nxt = ovf_b;
    if (ctl.feed && (phase_nxt == scl_pkg::NUM_SIGN) && (rx_char == scl_pkg::CHAR_MINUS)) begin
      neg_nxt = 1'b1;
    end
    if (ctl.feed && (phase_nxt == scl_pkg::NUM_DIGITS)) begin
      acc_nxt = prod[31:0];
      ovf_nxt = ovf_b | (prod[35:32] != 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= scl_pkg::NUM_LEAD;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
    end else if (ctl.step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_comb begin
    if (ovf_r) begin
      value = '1;
    end else if (neg_r) begin
      value = 32'd0 - acc_r;
    end else begin
      value = acc_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scl_checker.sv -----
// Port-level checks of the command line parser and their binding.
`default_nettype none

module scl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_command,
  input wire logic [31:0] out_first_value,
  input wire logic [31:0] out_second_value,
  input wire logic [1:0]  out_value_count
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command) &&
    $stable(out_first_value) && $stable(out_second_value) && $stable(out_value_count))
    else $error("result word changed while stalled");

  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_command <= 3'd4) && (out_value_count <= 2'd2))
    else $error("command or parameter count out of range");

  a_no_params: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value_count == 2'd0) |-> (out_first_value == 32'd0) &&
    (out_second_value == 32'd0))
    else $error("parameter value reported without a parameter token");

  a_one_param: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_value_count == 2'd1) |-> (out_second_value == 32'd0))
    else $error("second value reported with one parameter token");

  // The input side is never blocked while no word is held and no result waits.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !$past(in_valid && in_ready) |-> in_ready)
    else $error("input stalled with nothing in flight");

endmodule

bind serial_command_line_parser_top scl_checker u_scl_checker (.*);

`default_nettype wire
